>>> rtl/tvs_pkg.sv
package tvs_pkg;

  // Default store extent along each axis.
  localparam int MAX_X_DEF = 32;
  localparam int MAX_Y_DEF = 32;
  localparam int MAX_Z_DEF = 32;

  // Item commands.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SIZE_X = 3'd0,
    CFG_SIZE_Y = 3'd1,
    CFG_SIZE_Z = 3'd2,
    CFG_INV_X  = 3'd3,
    CFG_INV_Y  = 3'd4,
    CFG_INV_Z  = 3'd5
  } cfg_idx_t;

  // Register reset values.
  localparam logic [5:0]  SIZE_RESET = 6'd32;
  localparam logic [15:0] INV_RESET  = 16'd4096;

  // One in Q0.12, as a 13-bit weight.
  localparam logic [12:0] ONE_Q12 = 13'd4096;

  // Corner sequencer position of the last of the eight corners.
  localparam logic [2:0] LAST_CORNER = 3'd7;

  // Control that travels with each corner down the blend pipeline.
  typedef struct packed {
    logic valid;
    logic zero;
    logic first;
    logic last;
  } corner_tag_t;

endpackage

>>> rtl/tvs_ram.sv
module tvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: write on we, registered read of the addressed entry.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/trilinear_volume_sampler_core.sv
// A load is one memory write; a sample reads its eight corner voxels, one per cycle, from
// the single-ported voxel memory, and the next item waits until its last corner is read.
// out_valid rises once a result is buffered; with out_ready high it transfers in that
// cycle. Loads may follow each other in every cycle unless a sample holds the sequencer.
// Reset (synchronous, active low) clears the pipeline control and output buffer and
// returns the registers to their defaults; the voxel memory is not cleared.
module trilinear_volume_sampler_core #(
  parameter int MAX_X = tvs_pkg::MAX_X_DEF,
  parameter int MAX_Y = tvs_pkg::MAX_Y_DEF,
  parameter int MAX_Z = tvs_pkg::MAX_Z_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [4:0]         in_load_x,
  input  logic [4:0]         in_load_y,
  input  logic [4:0]         in_load_z,
  input  logic signed [15:0] in_load_value,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int XW    = $clog2(MAX_X);
  localparam int YW    = $clog2(MAX_Y);
  localparam int ZW    = $clog2(MAX_Z);
  localparam int AW    = XW + YW + ZW;
  localparam int DEPTH = 2 ** AW;

  // Configuration registers.
  logic [5:0]  size_x_r, size_y_r, size_z_r;
  logic [15:0] inv_x_r, inv_y_r, inv_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= tvs_pkg::SIZE_RESET;
      size_y_r <= tvs_pkg::SIZE_RESET;
      size_z_r <= tvs_pkg::SIZE_RESET;
      inv_x_r  <= tvs_pkg::INV_RESET;
      inv_y_r  <= tvs_pkg::INV_RESET;
      inv_z_r  <= tvs_pkg::INV_RESET;
    end else if (cfg_we) begin
      case (tvs_pkg::cfg_idx_t'(cfg_index))
        tvs_pkg::CFG_SIZE_X: size_x_r <= cfg_data[5:0];
        tvs_pkg::CFG_SIZE_Y: size_y_r <= cfg_data[5:0];
        tvs_pkg::CFG_SIZE_Z: size_z_r <= cfg_data[5:0];
        tvs_pkg::CFG_INV_X:  inv_x_r  <= cfg_data;
        tvs_pkg::CFG_INV_Y:  inv_y_r  <= cfg_data;
        tvs_pkg::CFG_INV_Z:  inv_z_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes in use, limited to the store extent.
  logic [8:0] eff_x, eff_y, eff_z;
  assign eff_x = ({3'b0, size_x_r} > 9'(MAX_X)) ? 9'(MAX_X) : {3'b0, size_x_r};
  assign eff_y = ({3'b0, size_y_r} > 9'(MAX_Y)) ? 9'(MAX_Y) : {3'b0, size_y_r};
  assign eff_z = ({3'b0, size_z_r} > 9'(MAX_Z)) ? 9'(MAX_Z) : {3'b0, size_z_r};

  // Handshake and flow control between stages.
  logic in_xfer, out_xfer;
  logic q_take, q_done, q_free;
  logic [1:0] pend_r;
  logic [1:0] fifo_cnt_r;

  // Stage P: the item and the three scaled positions (Q.24).
  logic                p_valid_r;
  logic                p_cmd_r;
  logic [4:0]          p_lx_r, p_ly_r, p_lz_r;
  logic signed [15:0]  p_val_r;
  logic signed [39:0]  p_sx_r, p_sy_r, p_sz_r;
  logic signed [40:0]  prod_x, prod_y, prod_z;

  assign in_ready = !p_valid_r || q_take;
  assign in_xfer  = in_valid && in_ready;

  assign prod_x = in_pos_x * $signed({1'b0, inv_x_r});
  assign prod_y = in_pos_y * $signed({1'b0, inv_y_r});
  assign prod_z = in_pos_z * $signed({1'b0, inv_z_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_xfer) begin
      p_valid_r <= 1'b1;
    end else if (q_take) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_cmd_r <= in_cmd;
      p_lx_r  <= in_load_x;
      p_ly_r  <= in_load_y;
      p_lz_r  <= in_load_z;
      p_val_r <= in_load_value;
      p_sx_r  <= prod_x[39:0];
      p_sy_r  <= prod_y[39:0];
      p_sz_r  <= prod_z[39:0];
    end
  end

  // Cell index truncated toward zero: floor plus one for a negative value with a fraction.
  function automatic logic signed [15:0] cell_of(input logic signed [39:0] p);
    cell_of = p[39:24] + {15'd0, p[39] && (p[23:0] != 24'd0)};
  endfunction

  // Fraction in Q0.12, zero for a negative position.
  function automatic logic [11:0] frac_of(input logic signed [39:0] p);
    frac_of = p[39] ? 12'd0 : p[23:12];
  endfunction

  // Load address and store bounds check.
  logic [8:0]    lx9, ly9, lz9;
  logic          l_inrange;
  logic [AW-1:0] l_addr;
  logic [11:0]   fu, fv, fw;

  assign lx9       = {4'd0, p_lx_r};
  assign ly9       = {4'd0, p_ly_r};
  assign lz9       = {4'd0, p_lz_r};
  assign l_inrange = (lx9 < 9'(MAX_X)) && (ly9 < 9'(MAX_Y)) && (lz9 < 9'(MAX_Z));
  assign l_addr    = {lz9[ZW-1:0], ly9[YW-1:0], lx9[XW-1:0]};
  assign fu        = frac_of(p_sx_r);
  assign fv        = frac_of(p_sy_r);
  assign fw        = frac_of(p_sz_r);

  // Stage Q: sequencer that owns the memory port, one access per cycle.
  logic                q_valid_r;
  logic                q_cmd_r;
  logic [2:0]          q_cnt_r;
  logic                q_wen_r;
  logic [AW-1:0]       q_waddr_r;
  logic signed [15:0]  q_wval_r;
  logic signed [15:0]  q_cx_r, q_cy_r, q_cz_r;
  logic [12:0]         q_wu0_r, q_wu1_r, q_wv0_r, q_wv1_r, q_ww0_r, q_ww1_r;

  assign q_done = q_valid_r &&
                  (q_cmd_r == tvs_pkg::CMD_LOAD || q_cnt_r == tvs_pkg::LAST_CORNER);
  assign q_free = !q_valid_r || q_done;
  assign q_take = p_valid_r && q_free && (p_cmd_r == tvs_pkg::CMD_LOAD || pend_r != 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
      q_cnt_r   <= 3'd0;
    end else if (q_take) begin
      q_valid_r <= 1'b1;
      q_cnt_r   <= 3'd0;
    end else if (q_done) begin
      q_valid_r <= 1'b0;
    end else if (q_valid_r) begin
      q_cnt_r <= q_cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      q_cmd_r   <= p_cmd_r;
      q_wen_r   <= l_inrange;
      q_waddr_r <= l_addr;
      q_wval_r  <= p_val_r;
      q_cx_r    <= cell_of(p_sx_r);
      q_cy_r    <= cell_of(p_sy_r);
      q_cz_r    <= cell_of(p_sz_r);
      q_wu0_r   <= tvs_pkg::ONE_Q12 - {1'b0, fu};
      q_wu1_r   <= {1'b0, fu};
      q_wv0_r   <= tvs_pkg::ONE_Q12 - {1'b0, fv};
      q_wv1_r   <= {1'b0, fv};
      q_ww0_r   <= tvs_pkg::ONE_Q12 - {1'b0, fw};
      q_ww1_r   <= {1'b0, fw};
    end
  end

  // Corner coordinates for the current read: bit 0 steps x, bit 1 y, bit 2 z.
  logic signed [16:0] cx, cy, cz;
  logic               c_inrange;
  logic [AW-1:0]      rd_addr;
  logic [12:0]        wu_sel, wv_sel, ww_sel;
  logic [25:0]        w2_full;

  assign cx = {q_cx_r[15], q_cx_r} + {16'd0, q_cnt_r[0]};
  assign cy = {q_cy_r[15], q_cy_r} + {16'd0, q_cnt_r[1]};
  assign cz = {q_cz_r[15], q_cz_r} + {16'd0, q_cnt_r[2]};

  assign c_inrange = !cx[16] && ($unsigned(cx) < {8'd0, eff_x}) &&
                     !cy[16] && ($unsigned(cy) < {8'd0, eff_y}) &&
                     !cz[16] && ($unsigned(cz) < {8'd0, eff_z});
  assign rd_addr   = {cz[ZW-1:0], cy[YW-1:0], cx[XW-1:0]};

  assign wu_sel  = q_cnt_r[0] ? q_wu1_r : q_wu0_r;
  assign wv_sel  = q_cnt_r[1] ? q_wv1_r : q_wv0_r;
  assign ww_sel  = q_cnt_r[2] ? q_ww1_r : q_ww0_r;
  assign w2_full = wv_sel * ww_sel;

  // Voxel memory. Loads and corner reads share the port in item order, so a read
  // always sees every load transferred before its sample.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_rdata;

  assign ram_we   = q_valid_r && (q_cmd_r == tvs_pkg::CMD_LOAD) && q_wen_r;
  assign ram_addr = (q_cmd_r == tvs_pkg::CMD_LOAD) ? q_waddr_r : rd_addr;

  tvs_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_voxel_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(q_wval_r),
    .rdata(ram_rdata)
  );

  // Stage D: control aligned with the registered read data.
  tvs_pkg::corner_tag_t d_tag_r, e_tag_r, f_tag_r;
  logic [12:0] d_wu_r;
  logic [24:0] d_w2_r, e_w2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_tag_r.valid <= 1'b0;
    end else begin
      d_tag_r.valid <= q_valid_r && (q_cmd_r == tvs_pkg::CMD_SAMPLE);
    end
    d_tag_r.zero  <= !c_inrange;
    d_tag_r.first <= (q_cnt_r == 3'd0);
    d_tag_r.last  <= (q_cnt_r == tvs_pkg::LAST_CORNER);
    d_wu_r        <= wu_sel;
    d_w2_r        <= w2_full[24:0];
  end

  // Stage E: voxel times x weight.
  logic signed [15:0] voxel;
  logic signed [28:0] a_full;
  logic signed [28:0] e_a_r;

  assign voxel  = d_tag_r.zero ? 16'sd0 : $signed(ram_rdata);
  assign a_full = voxel * $signed({1'b0, d_wu_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_tag_r.valid <= 1'b0;
    end else begin
      e_tag_r.valid <= d_tag_r.valid;
    end
    e_tag_r.zero  <= d_tag_r.zero;
    e_tag_r.first <= d_tag_r.first;
    e_tag_r.last  <= d_tag_r.last;
    e_a_r         <= a_full;
    e_w2_r        <= d_w2_r;
  end

  // Stage F: times the y and z weight product.
  logic signed [53:0] p_full;
  logic signed [53:0] f_p_r;

  assign p_full = e_a_r * $signed({1'b0, e_w2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_tag_r.valid <= 1'b0;
    end else begin
      f_tag_r.valid <= e_tag_r.valid;
    end
    f_tag_r.zero  <= e_tag_r.zero;
    f_tag_r.first <= e_tag_r.first;
    f_tag_r.last  <= e_tag_r.last;
    f_p_r         <= p_full;
  end

  // Accumulate the eight terms; the floored result is bits 51:36 of the sum.
  logic signed [55:0] acc_r;
  logic signed [55:0] acc_base, acc_nxt;
  logic               push;

  assign acc_base = f_tag_r.first ? 56'sd0 : acc_r;
  assign acc_nxt  = acc_base + f_p_r;
  assign push     = f_tag_r.valid && f_tag_r.last;

  always_ff @(posedge clk) begin
    if (f_tag_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  // Two-entry result buffer; the sample admission limit keeps it from overflowing.
  logic [15:0] fifo_r [2];
  logic        wr_ptr_r, rd_ptr_r;

  assign out_valid        = (fifo_cnt_r != 2'd0);
  assign out_sample_value = $signed(fifo_r[rd_ptr_r]);
  assign out_xfer         = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      fifo_cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (out_xfer) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, out_xfer})
        2'b10:   fifo_cnt_r <= fifo_cnt_r + 2'd1;
        2'b01:   fifo_cnt_r <= fifo_cnt_r - 2'd1;
        default: fifo_cnt_r <= fifo_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= acc_nxt[51:36];
    end
  end

  // Samples admitted to the sequencer whose results are not yet transferred.
  logic start_sample;
  logic [1:0] pend_nxt;

  assign start_sample = q_take && (p_cmd_r == tvs_pkg::CMD_SAMPLE);

  always_comb begin
    case ({start_sample, out_xfer})
      2'b10:   pend_nxt = pend_r + 2'd1;
      2'b01:   pend_nxt = pend_r - 2'd1;
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

`ifndef ASSERT_OFF
  // Every buffered result belongs to an admitted sample.
  a_fifo_within_pend: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= pend_r)
    else $error("result buffer holds more entries than admitted samples");

  // The buffer is never written while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_cnt_r != 2'd2))
    else $error("result buffer overflow");

  // Only a sample advances the corner counter.
  a_cnt_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid_r && q_cnt_r != 3'd0) |-> (q_cmd_r == tvs_pkg::CMD_SAMPLE))
    else $error("corner counter running on a load");

  // The last corner read produces a result once it has passed stages E and F.
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (d_tag_r.valid && d_tag_r.last) |-> ##2 push)
    else $error("last corner did not produce a result");
`endif

endmodule
